// File: rtl/lsv_pkg.sv
`default_nettype none
package lsv_pkg;

	localparam int DEPTH_MAX_DEF = 15;
	localparam int QDEPTH_DEF    = 2;

	// character kinds found by the front stage
	typedef logic [2:0] kind_t;
	localparam kind_t K_SPACE  = 3'd0;
	localparam kind_t K_TEXT   = 3'd1;
	localparam kind_t K_QUOTE  = 3'd2;
	localparam kind_t K_OPEN   = 3'd3;
	localparam kind_t K_CLOSE  = 3'd4;
	localparam kind_t K_COMMA  = 3'd5;
	localparam kind_t K_EQUALS = 3'd6;
	localparam kind_t K_BSLASH = 3'd7;

	// result character classes
	typedef logic [2:0] cls_t;
	localparam cls_t CLS_SPACE  = 3'd0;
	localparam cls_t CLS_SCALAR = 3'd1;
	localparam cls_t CLS_QUOTED = 3'd2;
	localparam cls_t CLS_OPEN   = 3'd3;
	localparam cls_t CLS_CLOSE  = 3'd4;
	localparam cls_t CLS_COMMA  = 3'd5;
	localparam cls_t CLS_EQUALS = 3'd6;

	typedef logic [3:0] err_t;
	localparam err_t ERR_NONE     = 4'd0;
	localparam err_t ERR_COMMA    = 4'd1;
	localparam err_t ERR_CLOSE    = 4'd2;
	localparam err_t ERR_ADJACENT = 4'd3;
	localparam err_t ERR_NOCOMMA  = 4'd4;
	localparam err_t ERR_CHAIN    = 4'd5;
	localparam err_t ERR_UNCLOSED = 4'd6;
	localparam err_t ERR_QUOTE    = 4'd7;
	localparam err_t ERR_OVERFLOW = 4'd8;

	// one classified beat travelling from front to back
	typedef struct packed {
		kind_t kind;
		logic  last_char;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// File: rtl/lsv_if.sv
`default_nettype none
interface lsv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last_char;

	modport source(output valid, ch, last_char, input ready);
	modport sink(input valid, ch, last_char, output ready);
endinterface

interface lsv_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] char_class;
	logic       token_start;
	logic [3:0] depth;
	logic [3:0] error_code;
	logic       done_res;

	modport source(output valid, char_class, token_start, depth, error_code, done_res,
		input ready);
	modport sink(input valid, char_class, token_start, depth, error_code, done_res,
		output ready);
endinterface
`default_nettype wire

// File: rtl/lsv_front.sv
`default_nettype none
module lsv_front (
	lsv_char_if.sink       chars,
	input  lsv_pkg::q_stat_t stat,
	output logic           push,
	output lsv_pkg::item_t wdata
);
	import lsv_pkg::*;

	kind_t kind;

	always_comb begin
		case (chars.ch) inside
			8'd32, [8'd9:8'd13]: kind = K_SPACE;
			8'd40:               kind = K_OPEN;
			8'd41:               kind = K_CLOSE;
			8'd44:               kind = K_COMMA;
			8'd61:               kind = K_EQUALS;
			8'd34:               kind = K_QUOTE;
			8'd92:               kind = K_BSLASH;
			default:             kind = K_TEXT;
		endcase
	end

	assign chars.ready     = !stat.full;
	assign push            = chars.valid && !stat.full;
	assign wdata.kind      = kind;
	assign wdata.last_char = chars.last_char;

endmodule
`default_nettype wire

// File: rtl/lsv_queue.sv
`default_nettype none
module lsv_queue #(
	parameter int QDEPTH = lsv_pkg::QDEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lsv_pkg::item_t   wdata,
	input  logic             pop,
	output lsv_pkg::item_t   rdata,
	output lsv_pkg::q_stat_t stat
);
	import lsv_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QDEPTH);

	item_t         mem [QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) mem[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			if (pop) rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign rdata      = mem[rptr_q];
	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);

endmodule
`default_nettype wire

// File: rtl/lsv_back.sv
`default_nettype none
module lsv_back #(
	parameter int DEPTH_MAX = lsv_pkg::DEPTH_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lsv_pkg::item_t   rdata,
	input  lsv_pkg::q_stat_t stat,
	output logic             pop,
	lsv_res_if.source        results
);
	import lsv_pkg::*;

	localparam int DW = $clog2(DEPTH_MAX + 1);
	localparam logic [DW-1:0] DMAX = DW'(DEPTH_MAX);

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_SCALAR = 2'd1;
	localparam logic [1:0] MODE_QUOTE  = 2'd2;

	localparam logic [2:0] TK_START  = 3'd0;
	localparam logic [2:0] TK_SCALAR = 3'd1;
	localparam logic [2:0] TK_OPEN   = 3'd2;
	localparam logic [2:0] TK_CLOSE  = 3'd3;
	localparam logic [2:0] TK_COMMA  = 3'd4;
	localparam logic [2:0] TK_EQUALS = 3'd5;

	logic [1:0]    mode_q, mode_n;
	logic          esc_q, esc_n;
	logic [2:0]    lt_q, lt_n, blt_q, blt_n;
	logic [DW-1:0] dep_q, dep_n;
	err_t          err_q, err_n;

	cls_t          cls;
	logic          start;
	logic [2:0]    tk;
	err_t          code;
	logic [DW+3:0] dep_ext;

	logic       out_valid_q;
	cls_t       cls_q;
	logic       start_q;
	logic [3:0] depth_q;
	err_t       error_q;
	logic       done_q;

	// next beat moves on when the output register is free or being drained
	assign pop = !stat.empty && (!out_valid_q || results.ready);

	always_comb begin
		mode_n = mode_q;
		esc_n  = esc_q;
		cls    = CLS_SPACE;
		start  = 1'b0;
		tk     = TK_SCALAR;
		if (mode_q == MODE_QUOTE) begin
			cls = CLS_QUOTED;
			if (rdata.kind == K_QUOTE && !esc_q) mode_n = MODE_IDLE;
			esc_n = (rdata.kind == K_BSLASH);
		end else begin
			case (rdata.kind)
				K_SPACE: cls = CLS_SPACE;
				K_OPEN: begin
					cls = CLS_OPEN; tk = TK_OPEN; start = 1'b1; mode_n = MODE_IDLE;
				end
				K_CLOSE: begin
					cls = CLS_CLOSE; tk = TK_CLOSE; start = 1'b1; mode_n = MODE_IDLE;
				end
				K_COMMA: begin
					cls = CLS_COMMA; tk = TK_COMMA; start = 1'b1; mode_n = MODE_IDLE;
				end
				K_EQUALS: begin
					cls = CLS_EQUALS; tk = TK_EQUALS; start = 1'b1; mode_n = MODE_IDLE;
				end
				K_QUOTE: begin
					if (mode_q == MODE_IDLE) begin
						cls = CLS_QUOTED; start = 1'b1; mode_n = MODE_QUOTE; esc_n = 1'b0;
					end else begin
						cls = CLS_SCALAR;
					end
				end
				default: begin
					cls = CLS_SCALAR;
					if (mode_q == MODE_IDLE) begin
						start  = 1'b1;
						mode_n = MODE_SCALAR;
					end
				end
			endcase
		end

		// rule checks against the depth and tokens before this one
		if (dep_q == '0 && tk == TK_COMMA) code = ERR_COMMA;
		else if (dep_q == '0 && tk == TK_CLOSE) code = ERR_CLOSE;
		else if (lt_q == TK_SCALAR && tk == TK_SCALAR) code = ERR_ADJACENT;
		else if (lt_q == TK_CLOSE && tk != TK_COMMA && tk != TK_CLOSE) code = ERR_NOCOMMA;
		else if (blt_q == TK_EQUALS && lt_q == TK_SCALAR && tk == TK_EQUALS) code = ERR_CHAIN;
		else code = ERR_NONE;

		err_n = err_q;
		dep_n = dep_q;
		lt_n  = lt_q;
		blt_n = blt_q;
		if (start) begin
			if (err_q == ERR_NONE) err_n = code;
			if (tk == TK_OPEN) begin
				if (dep_q >= DMAX) begin
					if (err_n == ERR_NONE) err_n = ERR_OVERFLOW;
				end else begin
					dep_n = dep_q + 1'b1;
				end
			end else if (tk == TK_CLOSE && dep_q != '0) begin
				dep_n = dep_q - 1'b1;
			end
			blt_n = lt_q;
			lt_n  = tk;
		end

		if (rdata.last_char && err_n == ERR_NONE) begin
			if (mode_n == MODE_QUOTE) err_n = ERR_QUOTE;
			else if (dep_n != '0) err_n = ERR_UNCLOSED;
		end

		dep_ext = {4'b0000, dep_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			esc_q       <= 1'b0;
			lt_q        <= TK_START;
			blt_q       <= TK_START;
			dep_q       <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (rdata.last_char) begin
					// label done, start the next one clean
					mode_q <= MODE_IDLE;
					esc_q  <= 1'b0;
					lt_q   <= TK_START;
					blt_q  <= TK_START;
					dep_q  <= '0;
					err_q  <= ERR_NONE;
				end else begin
					mode_q <= mode_n;
					esc_q  <= esc_n;
					lt_q   <= lt_n;
					blt_q  <= blt_n;
					dep_q  <= dep_n;
					err_q  <= err_n;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cls_q   <= cls;
			start_q <= start;
			depth_q <= dep_ext[3:0];
			error_q <= err_n;
			done_q  <= rdata.last_char;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.char_class  = cls_q;
	assign results.token_start = start_q;
	assign results.depth       = depth_q;
	assign results.error_code  = error_q;
	assign results.done_res    = done_q;

endmodule
`default_nettype wire

// File: rtl/label_syntax_validator_unit.sv
`default_nettype none
// Label syntax validator: takes one label character per beat on chars (last_char marks the
// end of a label) and returns one result beat per character on results with its class,
// token start flag, scope depth and the first syntax error seen so far in this label.
// Sustained rate is one character per cycle while results is ready; each result is
// registered first in the classify queue and then in the output register, behind the
// combinational lexer and rule update in the back stage. The queue holds QDEPTH beats, so
// input keeps flowing for a while when results stalls. Lexer and rule state resets after
// the final character of a label. DEPTH_MAX sets the deepest allowed scope nesting.
module label_syntax_validator_unit #(
	parameter int DEPTH_MAX = lsv_pkg::DEPTH_MAX_DEF,
	parameter int QDEPTH    = lsv_pkg::QDEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lsv_char_if.sink  chars,
	lsv_res_if.source results
);
	import lsv_pkg::*;

	logic    push, pop;
	item_t   wdata, rdata;
	q_stat_t stat;

	lsv_front u_front (
		.chars (chars),
		.stat  (stat),
		.push  (push),
		.wdata (wdata)
	);

	lsv_queue #(.QDEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.stat   (stat)
	);

	lsv_back #(.DEPTH_MAX(DEPTH_MAX)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rdata   (rdata),
		.stat    (stat),
		.pop     (pop),
		.results (results)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready |-> !stat.full)
		else $error("beat accepted into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from an empty queue");

	a_pop_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> results.valid)
		else $error("popped beat did not reach the output register");

	a_clean_end: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.done_res && results.error_code == ERR_NONE
		|-> results.depth == 4'd0)
		else $error("label ended without error at nonzero depth");

	a_start_class: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.token_start |-> results.char_class != CLS_SPACE)
		else $error("token start on a space");

endmodule
`default_nettype wire
